// ===== src/yrs_pkg.sv =====
`timescale 1ns / 1ps

package yrs_pkg;

  // Fixed field widths
  localparam int LUMA_W    = 8;
  localparam int CHROMA_W  = 8;
  localparam int COLOR_W   = 8;
  localparam int COEF_W    = 16;
  localparam int STEP_W    = 21;
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 3;

  // Default replication limit
  localparam int MAX_UPSCALE_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_U_TO_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_U_TO_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V_TO_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V_TO_RED   = 3'd5;

  // Register reset values
  localparam logic [STEP_W-1:0]        X_STEP_RST     = 21'h010000;
  localparam logic signed [COEF_W-1:0] LUMA_GAIN_RST  = 16'sd9535;
  localparam logic signed [COEF_W-1:0] U_TO_BLUE_RST  = 16'sd16531;
  localparam logic signed [COEF_W-1:0] U_TO_GREEN_RST = -16'sd3203;
  localparam logic signed [COEF_W-1:0] V_TO_GREEN_RST = -16'sd6660;
  localparam logic signed [COEF_W-1:0] V_TO_RED_RST   = 16'sd13074;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul_en;
    logic sum_en;
    logic emit_step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;
    logic cnt_last;
  } dp_flag_t;

endpackage

// ===== src/yrs_ctrl.sv =====
`timescale 1ns / 1ps

module yrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  yrs_pkg::dp_flag_t status,
  output yrs_pkg::cmd_t     cmd
);

  yrs_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      yrs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = yrs_pkg::ST_MUL;
      end
      yrs_pkg::ST_MUL: begin
        state_nxt = yrs_pkg::ST_SUM;
      end
      yrs_pkg::ST_SUM: begin
        // no copies for this pixel: done at once
        state_nxt = status.cnt_zero ? yrs_pkg::ST_IDLE : yrs_pkg::ST_EMIT;
      end
      yrs_pkg::ST_EMIT: begin
        if (out_ready && status.cnt_last) state_nxt = yrs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = yrs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.load      = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.sum_en    = 1'b0;
    cmd.emit_step = 1'b0;
    case (state_r)
      yrs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      yrs_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
      end
      yrs_pkg::ST_SUM: begin
        cmd.sum_en = 1'b1;
      end
      yrs_pkg::ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= yrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/yrs_datapath.sv =====
`timescale 1ns / 1ps

module yrs_datapath #(
  parameter int MAX_UPSCALE = yrs_pkg::MAX_UPSCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [yrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yrs_pkg::CFG_W-1:0]       cfg_data,
  input  logic [yrs_pkg::LUMA_W-1:0]      in_luma,
  input  logic [yrs_pkg::CHROMA_W-1:0]    in_chroma_u,
  input  logic [yrs_pkg::CHROMA_W-1:0]    in_chroma_v,
  input  logic                            in_row_start,
  input  yrs_pkg::cmd_t                   cmd,
  output yrs_pkg::dp_flag_t               status,
  output logic [yrs_pkg::COLOR_W-1:0]     out_red,
  output logic [yrs_pkg::COLOR_W-1:0]     out_green,
  output logic [yrs_pkg::COLOR_W-1:0]     out_blue,
  output logic                            out_last_copy
);

  localparam int FW   = yrs_pkg::FRAC_W;
  localparam int CW   = $clog2(MAX_UPSCALE + 1);
  localparam int AW   = FW + CW;
  localparam int CMPW = (yrs_pkg::STEP_W > AW) ? yrs_pkg::STEP_W : AW;
  localparam int OPW  = 12;                   // scaled luma / chroma operand
  localparam int PW   = OPW + yrs_pkg::COEF_W; // full product
  localparam int SW   = OPW + 2;              // sum before clamping
  localparam logic [CMPW-1:0] STEP_LIMIT = CMPW'(MAX_UPSCALE) << FW;

  // Configuration registers
  logic [yrs_pkg::STEP_W-1:0]        x_step_r;
  logic signed [yrs_pkg::COEF_W-1:0] luma_gain_r, u_to_blue_r, u_to_green_r;
  logic signed [yrs_pkg::COEF_W-1:0] v_to_green_r, v_to_red_r;

  // Control state
  logic [FW-1:0] xacc_r, xacc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Operand, product and color registers
  logic signed [OPW-1:0] ya_r, ua_r, va_r;
  logic signed [OPW-1:0] ya_nxt, ua_nxt, va_nxt;
  logic signed [OPW-1:0] yp_r, ub_r, ug_r, vg_r, vr_r;
  logic signed [OPW-1:0] yp_nxt, ub_nxt, ug_nxt, vg_nxt, vr_nxt;
  logic [yrs_pkg::COLOR_W-1:0] red_r, green_r, blue_r;
  logic [yrs_pkg::COLOR_W-1:0] red_nxt, green_nxt, blue_nxt;

  logic [CMPW-1:0]         step_ext, step_lim;
  logic [AW-1:0]           acc;
  logic [yrs_pkg::LUMA_W-1:0]   y_off;
  logic [yrs_pkg::CHROMA_W-1:0] u_off, v_off;
  logic signed [PW-1:0]    p_y, p_ub, p_ug, p_vg, p_vr;
  logic signed [OPW:0]     g_chroma;
  logic signed [SW-1:0]    r_sum, g_sum, b_sum;

  function automatic logic [yrs_pkg::COLOR_W-1:0] clamp_u8(input logic signed [SW-1:0] v);
    logic [yrs_pkg::COLOR_W-1:0] res;
    if (v < 0) res = '0;
    else if (v > SW'(255)) res = '1;
    else res = v[yrs_pkg::COLOR_W-1:0];
    return res;
  endfunction

  // Horizontal accumulator: new position and copy count
  always_comb begin
    step_ext = CMPW'(x_step_r);
    step_lim = (step_ext > STEP_LIMIT) ? STEP_LIMIT : step_ext;
    acc      = AW'(in_row_start ? '0 : xacc_r) + AW'(step_lim);
  end

  // Operand scaling: luma offset with floor at zero, chroma recentered, all times 8
  always_comb begin
    y_off  = (in_luma > 8'd16) ? (in_luma - 8'd16) : '0;
    u_off  = {~in_chroma_u[7], in_chroma_u[6:0]};
    v_off  = {~in_chroma_v[7], in_chroma_v[6:0]};
    ya_nxt = {1'b0, y_off, 3'b000};
    ua_nxt = {u_off[7], u_off, 3'b000};
    va_nxt = {v_off[7], v_off, 3'b000};
  end

  // Products, high half (floor of product / 65536)
  always_comb begin
    p_y    = ya_r * luma_gain_r;
    p_ub   = ua_r * u_to_blue_r;
    p_ug   = ua_r * u_to_green_r;
    p_vg   = va_r * v_to_green_r;
    p_vr   = va_r * v_to_red_r;
    yp_nxt = p_y[PW-1:FW];
    ub_nxt = p_ub[PW-1:FW];
    ug_nxt = p_ug[PW-1:FW];
    vg_nxt = p_vg[PW-1:FW];
    vr_nxt = p_vr[PW-1:FW];
  end

  // Sums and clamp; terms are small enough that 16-bit saturation never bites
  always_comb begin
    g_chroma  = {ug_r[OPW-1], ug_r} + {vg_r[OPW-1], vg_r};
    r_sum     = {{2{yp_r[OPW-1]}}, yp_r} + {{2{vr_r[OPW-1]}}, vr_r};
    b_sum     = {{2{yp_r[OPW-1]}}, yp_r} + {{2{ub_r[OPW-1]}}, ub_r};
    g_sum     = {{2{yp_r[OPW-1]}}, yp_r} + {g_chroma[OPW], g_chroma};
    red_nxt   = clamp_u8(r_sum);
    green_nxt = clamp_u8(g_sum);
    blue_nxt  = clamp_u8(b_sum);
  end

  // Accumulator and copy counter next values
  always_comb begin
    xacc_nxt = xacc_r;
    cnt_nxt  = cnt_r;
    if (cmd.load) begin
      xacc_nxt = acc[FW-1:0];
      cnt_nxt  = acc[AW-1:FW];
    end else if (cmd.emit_step) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r     <= yrs_pkg::X_STEP_RST;
      luma_gain_r  <= yrs_pkg::LUMA_GAIN_RST;
      u_to_blue_r  <= yrs_pkg::U_TO_BLUE_RST;
      u_to_green_r <= yrs_pkg::U_TO_GREEN_RST;
      v_to_green_r <= yrs_pkg::V_TO_GREEN_RST;
      v_to_red_r   <= yrs_pkg::V_TO_RED_RST;
      xacc_r       <= '0;
      cnt_r        <= '0;
    end else begin
      xacc_r <= xacc_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          yrs_pkg::REG_X_STEP:     x_step_r     <= cfg_data[yrs_pkg::STEP_W-1:0];
          yrs_pkg::REG_LUMA_GAIN:  luma_gain_r  <= cfg_data[yrs_pkg::COEF_W-1:0];
          yrs_pkg::REG_U_TO_BLUE:  u_to_blue_r  <= cfg_data[yrs_pkg::COEF_W-1:0];
          yrs_pkg::REG_U_TO_GREEN: u_to_green_r <= cfg_data[yrs_pkg::COEF_W-1:0];
          yrs_pkg::REG_V_TO_GREEN: v_to_green_r <= cfg_data[yrs_pkg::COEF_W-1:0];
          yrs_pkg::REG_V_TO_RED:   v_to_red_r   <= cfg_data[yrs_pkg::COEF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ya_r <= ya_nxt;
      ua_r <= ua_nxt;
      va_r <= va_nxt;
    end
    if (cmd.mul_en) begin
      yp_r <= yp_nxt;
      ub_r <= ub_nxt;
      ug_r <= ug_nxt;
      vg_r <= vg_nxt;
      vr_r <= vr_nxt;
    end
    if (cmd.sum_en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign status.cnt_zero = (cnt_r == '0);
  assign status.cnt_last = (cnt_r == CW'(1));

  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_last_copy = status.cnt_last;

endmodule

// ===== src/yuv_to_rgb32_horizontal_scaler_top.sv =====
// Sequencing: after the input transaction the sequencer runs the multiply state, then the
// sum/clamp state, then emits n copies (n = 0..MAX_UPSCALE), one copy per cycle while out_ready
// is high; a new input is accepted only after the last copy, back in the idle state.
// Reset (rst_n, synchronous): sequencer to idle, accumulator cleared,
// configuration registers to their default values.
`timescale 1ns / 1ps

module yuv_to_rgb32_horizontal_scaler_top #(
  parameter int MAX_UPSCALE = yrs_pkg::MAX_UPSCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [yrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yrs_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [yrs_pkg::LUMA_W-1:0]      in_luma,
  input  logic [yrs_pkg::CHROMA_W-1:0]    in_chroma_u,
  input  logic [yrs_pkg::CHROMA_W-1:0]    in_chroma_v,
  input  logic                            in_row_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [yrs_pkg::COLOR_W-1:0]     out_red,
  output logic [yrs_pkg::COLOR_W-1:0]     out_green,
  output logic [yrs_pkg::COLOR_W-1:0]     out_blue,
  output logic                            out_last_copy
);

  yrs_pkg::cmd_t     cmd;
  yrs_pkg::dp_flag_t status;

  yrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  yrs_datapath #(
    .MAX_UPSCALE (MAX_UPSCALE)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_luma       (in_luma),
    .in_chroma_u   (in_chroma_u),
    .in_chroma_v   (in_chroma_v),
    .in_row_start  (in_row_start),
    .cmd           (cmd),
    .status        (status),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last_copy (out_last_copy)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import yrs_pkg::*;

  localparam int ONE_UNIT    = 'h10000;
  localparam int MAX_COPIES  = MAX_UPSCALE_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 8;

  // Indexes past the register file; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_copy;
  } rgb_pixel_t;

  // Color conversion and replication predictor with the queue of pending pixels
  class rgb_scoreboard;
    logic [STEP_W-1:0]        x_step;
    logic signed [COEF_W-1:0] luma_gain;
    logic signed [COEF_W-1:0] u_to_blue;
    logic signed [COEF_W-1:0] u_to_green;
    logic signed [COEF_W-1:0] v_to_green;
    logic signed [COEF_W-1:0] v_to_red;
    int                       x_pos;
    rgb_pixel_t               pending_q[$];
    int                       errors;
    int                       pixels_in;
    int                       pixels_out;

    function new();
      x_step     = X_STEP_RST;
      luma_gain  = LUMA_GAIN_RST;
      u_to_blue  = U_TO_BLUE_RST;
      u_to_green = U_TO_GREEN_RST;
      v_to_green = V_TO_GREEN_RST;
      v_to_red   = V_TO_RED_RST;
      x_pos      = 0;
      errors     = 0;
      pixels_in  = 0;
      pixels_out = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_X_STEP:     x_step     = data[STEP_W-1:0];
        REG_LUMA_GAIN:  luma_gain  = data[COEF_W-1:0];
        REG_U_TO_BLUE:  u_to_blue  = data[COEF_W-1:0];
        REG_U_TO_GREEN: u_to_green = data[COEF_W-1:0];
        REG_V_TO_GREEN: v_to_green = data[COEF_W-1:0];
        REG_V_TO_RED:   v_to_red   = data[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(a * c / 65536); products stay well inside 32 bits
    function int fix_mul(int a, int c);
      int p;
      p = a * c;
      return p >>> 16;
    endfunction

    function int sat16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function logic [COLOR_W-1:0] clamp8(int v);
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[COLOR_W-1:0];
    endfunction

    function void note_input(logic [LUMA_W-1:0] luma, logic [CHROMA_W-1:0] cu,
                             logic [CHROMA_W-1:0] cv, logic row_start);
      int         y_off;
      int         u_off;
      int         v_off;
      int         y_term;
      int         step;
      int         acc;
      int         copies;
      rgb_pixel_t px;
      y_off  = (int'(luma) > 16) ? int'(luma) - 16 : 0;
      u_off  = (int'(cu) - 128) * 8;
      v_off  = (int'(cv) - 128) * 8;
      y_term = fix_mul(y_off * 8, int'(luma_gain));
      px.blue  = clamp8(sat16(y_term + fix_mul(u_off, int'(u_to_blue))));
      px.red   = clamp8(sat16(y_term + fix_mul(v_off, int'(v_to_red))));
      px.green = clamp8(sat16(y_term + sat16(fix_mul(u_off, int'(u_to_green)) +
                                             fix_mul(v_off, int'(v_to_green)))));
      // step is capped at the upscale limit
      step = int'(x_step);
      if (step > (MAX_COPIES << 16)) step = MAX_COPIES << 16;
      acc = (row_start ? 0 : (x_pos & 'hFFFF)) + step;
      copies = 0;
      while (acc >= ONE_UNIT && copies < MAX_COPIES) begin
        acc -= ONE_UNIT;
        copies++;
      end
      for (int k = 0; k < copies; k++) begin
        px.last_copy = (k == copies - 1);
        pending_q.push_back(px);
      end
      x_pos = acc & 'h1FFFFF;
      pixels_in++;
    endfunction

    function void check_result(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                               logic [COLOR_W-1:0] b, logic last_copy);
      rgb_pixel_t want;
      if (pending_q.size() == 0) begin
        $error("output pixel with none pending: red %0d green %0d blue %0d", r, g, b);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      pixels_out++;
      if (r !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, r);
        errors++;
      end
      if (g !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, g);
        errors++;
      end
      if (b !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, b);
        errors++;
      end
      if (last_copy !== want.last_copy) begin
        $error("last_copy: expected %0d, got %0d", want.last_copy, last_copy);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LUMA_W-1:0]    in_luma = '0;
  logic [CHROMA_W-1:0]  in_chroma_u = '0;
  logic [CHROMA_W-1:0]  in_chroma_v = '0;
  logic                 in_row_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COLOR_W-1:0]   out_red;
  logic [COLOR_W-1:0]   out_green;
  logic [COLOR_W-1:0]   out_blue;
  logic                 out_last_copy;

  logic                 steady = 1'b0;
  int                   quiet_cycles = 0;
  int                   settings_used = 0;
  rgb_scoreboard        sb = new();

  yuv_to_rgb32_horizontal_scaler_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_luma       (in_luma),
    .in_chroma_u   (in_chroma_u),
    .in_chroma_v   (in_chroma_v),
    .in_row_start  (in_row_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last_copy (out_last_copy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 17);
  end

  // Transaction monitors on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_luma, in_chroma_u, in_chroma_v, in_row_start);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_red, out_green, out_blue, out_last_copy);
  end

  // Watchdog: too long without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [LUMA_W-1:0] y, input logic [CHROMA_W-1:0] u,
                            input logic [CHROMA_W-1:0] v, input logic rs);
    if (!steady) begin
      while ($urandom_range(0, 99) < 17) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_luma      <= y;
    in_chroma_u  <= u;
    in_chroma_v  <= v;
    in_row_start <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random_pixel(input logic rs);
    logic [CHROMA_W-1:0] u;
    logic [CHROMA_W-1:0] v;
    u = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                    : 8'($urandom_range(0, 255));
    v = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                    : 8'($urandom_range(0, 255));
    send_pixel(8'($urandom_range(0, 255)), u, v, rs);
  endtask

  // Stop sending, wait for every pending pixel, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Coefficients carry junk above bit 15, which the block must drop
  task automatic apply_setting(input logic [STEP_W-1:0] step,
                               input logic [COEF_W-1:0] lg, input logic [COEF_W-1:0] ub,
                               input logic [COEF_W-1:0] ug, input logic [COEF_W-1:0] vg,
                               input logic [COEF_W-1:0] vr);
    cfg_write(REG_X_STEP, step);
    cfg_write(REG_LUMA_GAIN, {5'($urandom_range(0, 31)), lg});
    cfg_write(REG_U_TO_BLUE, {5'($urandom_range(0, 31)), ub});
    cfg_write(REG_U_TO_GREEN, {5'($urandom_range(0, 31)), ug});
    cfg_write(REG_V_TO_GREEN, {5'($urandom_range(0, 31)), vg});
    cfg_write(REG_V_TO_RED, {5'($urandom_range(0, 31)), vr});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 21'h1FFFFF;
      2:       return STEP_W'(MAX_COPIES << 16);
      3:       return STEP_W'($urandom_range(0, 21'h1FFFFF));
      4:       return STEP_W'(ONE_UNIT);
      5:       return STEP_W'($urandom_range(1, 'hFFFF));
      default: return STEP_W'($urandom_range('h2000, 'h28000));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(input logic signed [COEF_W-1:0] nominal);
    case ($urandom_range(0, 9))
      6, 7:    return COEF_W'($urandom_range(0, 'hFFFF));
      8:       return 16'h8000;
      9:       return 16'h7FFF;
      default: return nominal + COEF_W'($urandom_range(0, 4095)) - 16'sd2048;
    endcase
  endfunction

  initial begin
    int phase;
    int n_items;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: luma and chroma extremes, black level edge, row start
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd16, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd17, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
    drain();

    // Half step: pixels alternate between zero and one copy
    apply_setting(21'h008000, LUMA_GAIN_RST, U_TO_BLUE_RST, U_TO_GREEN_RST,
                  V_TO_GREEN_RST, V_TO_RED_RST);
    send_pixel(8'd200, 8'd60, 8'd200, 1'b0);
    send_pixel(8'd50, 8'd200, 8'd60, 1'b0);
    send_pixel(8'd100, 8'd100, 8'd100, 1'b1);
    send_pixel(8'd235, 8'd16, 8'd240, 1'b0);
    drain();

    // Writes past the register file, then a step over the upscale limit
    cfg_write(REG_SPARE_LO, CFG_W'($urandom_range(0, 21'h1FFFFF)));
    cfg_write(REG_SPARE_HI, CFG_W'($urandom_range(0, 21'h1FFFFF)));
    apply_setting(21'h1FFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd170, 8'd85, 8'd170, 1'b0);
    drain();

    // Zero step: no output at all
    apply_setting('0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd85, 8'd170, 8'd85, 1'b0);
    drain();

    // Step exactly at the limit, chroma terms zeroed
    apply_setting(STEP_W'(MAX_COPIES << 16), 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000);
    send_pixel(8'd240, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd17, 8'd255, 8'd0, 1'b0);
    drain();

    // Random phases, each under its own register setting
    phase = 0;
    while (sb.pixels_in < 420) begin
      apply_setting(pick_step(), pick_coef(LUMA_GAIN_RST), pick_coef(U_TO_BLUE_RST),
                    pick_coef(U_TO_GREEN_RST), pick_coef(V_TO_GREEN_RST),
                    pick_coef(V_TO_RED_RST));
      steady <= (phase == 1);
      n_items = $urandom_range(20, 50);
      for (int i = 0; i < n_items; i++) begin
        // in phase 2 only, the sender holds off until the block has emptied, once mid-phase
        if (phase == 2 && i == n_items / 2) drain();
        send_random_pixel((i == 0) || ($urandom_range(0, 11) == 0));
      end
      drain();
      steady <= 1'b0;
      phase++;
    end

    drain();
    if (sb.pending_q.size() != 0) begin
      $error("%0d output pixels never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("Covered %0d source pixels under %0d register settings, %0d output pixels checked.",
             sb.pixels_in, settings_used, sb.pixels_out);
    $display("Mismatches found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
